// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
// No dependencies; used by spq_cell and sorted_priority_queue_top.
package spq_pkg;

	localparam int ValueW = 32;
	localparam int PrioW  = 16;
	localparam int OccW   = 5;

	// Operation codes on the operation input
	typedef enum logic {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_UNDERFLOW = 2'd1,
		ST_OVERFLOW  = 2'd2
	} status_t;

	// Command broadcast to every cell of the chain
	typedef struct packed {
		logic                     ins_en;
		logic                     del_en;
		logic signed [ValueW-1:0] new_value;
		logic signed [PrioW-1:0]  new_priority;
	} cmd_t;

endpackage

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted shift chain: holds a value/priority pair.
// Depends on spq_pkg for the command struct and field widths.
module spq_cell (
	input  logic                              clk,
	input  spq_pkg::cmd_t                     cmd,
	input  logic                              occupied,
	input  logic                              left_keep,
	input  logic signed [spq_pkg::ValueW-1:0] left_value,
	input  logic signed [spq_pkg::PrioW-1:0]  left_priority,
	input  logic signed [spq_pkg::ValueW-1:0] right_value,
	input  logic signed [spq_pkg::PrioW-1:0]  right_priority,
	output logic                              keep,
	output logic signed [spq_pkg::ValueW-1:0] value,
	output logic signed [spq_pkg::PrioW-1:0]  priority_o
);

	logic signed [spq_pkg::ValueW-1:0] value_q;
	logic signed [spq_pkg::PrioW-1:0]  prio_q;

	// Entry stays put on insert if it ranks ahead of or ties the new pair
	assign keep       = occupied && (prio_q >= cmd.new_priority);
	assign value      = value_q;
	assign priority_o = prio_q;

	// Insert: hold, take the new pair, or shift in from the left.
	// Delete: shift in from the right.
	always_ff @(posedge clk) begin
		if (cmd.ins_en) begin
			if (!keep) begin
				if (left_keep) begin
					value_q <= cmd.new_value;
					prio_q  <= cmd.new_priority;
				end else begin
					value_q <= left_value;
					prio_q  <= left_priority;
				end
			end
		end else if (cmd.del_en) begin
			value_q <= right_value;
			prio_q  <= right_priority;
		end
	end

endmodule

// ===== rtl/core/sorted_priority_queue_top.sv =====
// Sorted priority queue: one command beat per cycle, result registered.
// done pulses on the cycle after start; throughput one beat per cycle.
// The whole chain of DEPTH cells shifts in parallel, so busy never rises.
// Reset clears the count and the result strobe; slot contents are not reset.
// Results cannot be stalled by the receiver.
// Depends on spq_pkg and spq_cell.
module sorted_priority_queue_top #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic signed [spq_pkg::ValueW-1:0] item_value,
	input  logic signed [spq_pkg::PrioW-1:0]  item_priority,
	output logic        done,
	output logic [1:0]  status,
	output logic signed [spq_pkg::ValueW-1:0] removed_value,
	output logic signed [spq_pkg::PrioW-1:0]  removed_priority,
	output logic [spq_pkg::OccW-1:0]          occupancy
);

	localparam int CntW = $clog2(DEPTH + 1);

	logic [CntW-1:0]     count_q;
	logic [CntW-1:0]     count_nxt;
	logic                accept;
	logic                is_full;
	logic                is_empty;
	spq_pkg::cmd_t       cmd;
	spq_pkg::status_t    status_nxt;

	logic                              keep_w  [DEPTH];
	logic signed [spq_pkg::ValueW-1:0] value_w [DEPTH];
	logic signed [spq_pkg::PrioW-1:0]  prio_w  [DEPTH];

	logic                              done_q;
	spq_pkg::status_t                  status_q;
	logic signed [spq_pkg::ValueW-1:0] rvalue_q;
	logic signed [spq_pkg::PrioW-1:0]  rprio_q;

	assign busy     = 1'b0;
	assign accept   = start && !busy;
	assign is_full  = (count_q == CntW'(DEPTH));
	assign is_empty = (count_q == '0);

	// Decode the beat into a chain command
	always_comb begin
		cmd.ins_en       = accept && (operation == spq_pkg::OP_INSERT) && !is_full;
		cmd.del_en       = accept && (operation == spq_pkg::OP_DELETE) && !is_empty;
		cmd.new_value    = item_value;
		cmd.new_priority = item_priority;
	end

	// Status and next count
	always_comb begin
		status_nxt = spq_pkg::ST_OK;
		count_nxt  = count_q;
		if (operation == spq_pkg::OP_INSERT) begin
			if (is_full) status_nxt = spq_pkg::ST_OVERFLOW;
			else count_nxt = count_q + CntW'(1);
		end else begin
			if (is_empty) status_nxt = spq_pkg::ST_UNDERFLOW;
			else count_nxt = count_q - CntW'(1);
		end
	end

	// Chain of cells, head at index 0
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic                              l_keep;
		logic signed [spq_pkg::ValueW-1:0] l_value;
		logic signed [spq_pkg::PrioW-1:0]  l_prio;
		logic signed [spq_pkg::ValueW-1:0] r_value;
		logic signed [spq_pkg::PrioW-1:0]  r_prio;

		if (i == 0) begin : g_head
			assign l_keep  = 1'b1;
			assign l_value = item_value;
			assign l_prio  = item_priority;
		end else begin : g_body
			assign l_keep  = keep_w[i-1];
			assign l_value = value_w[i-1];
			assign l_prio  = prio_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_tail
			assign r_value = value_w[i];
			assign r_prio  = prio_w[i];
		end else begin : g_mid
			assign r_value = value_w[i+1];
			assign r_prio  = prio_w[i+1];
		end

		spq_cell u_cell (
			.clk            (clk),
			.cmd            (cmd),
			.occupied       (CntW'(i) < count_q),
			.left_keep      (l_keep),
			.left_value     (l_value),
			.left_priority  (l_prio),
			.right_value    (r_value),
			.right_priority (r_prio),
			.keep           (keep_w[i]),
			.value          (value_w[i]),
			.priority_o     (prio_w[i])
		);
	end

	// Count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= accept;
			if (accept) count_q <= count_nxt;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status_q <= status_nxt;
			if (cmd.del_en) begin
				rvalue_q <= value_w[0];
				rprio_q  <= prio_w[0];
			end else begin
				rvalue_q <= '0;
				rprio_q  <= '0;
			end
		end
	end

	assign done             = done_q;
	assign status           = status_q;
	assign removed_value    = rvalue_q;
	assign removed_priority = rprio_q;
	assign occupancy        = spq_pkg::OccW'(count_q);

endmodule
